// ===== rtl/split_class_weight_stats_assert.svh =====
// Assertion macros used by the split statistics RTL.
`ifndef SPLIT_CLASS_WEIGHT_STATS_ASSERT_SVH
`define SPLIT_CLASS_WEIGHT_STATS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SCWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SCWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scws_pkg.sv =====
// Shared constants and types of the split class-weight statistics block.
package scws_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int NODE_BITS_DEF   = 16;
  localparam int SUM_BITS_DEF    = 40;

  localparam int LABEL_W      = 5;
  localparam int CLASS_OUT_W  = 4;
  localparam int WEIGHT_OUT_W = 40;
  localparam int FRAC_BITS    = 16;
  localparam int SET_W        = 2;
  localparam int SPLIT_W      = 15;
  localparam int NCLS_W       = 5;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = 5'd2;

  localparam logic [0:0] REG_SPLIT_NODE  = 1'b0;
  localparam logic [0:0] REG_NUM_CLASSES = 1'b1;

  localparam logic [SET_W-1:0] SET_NODE  = 2'd0;
  localparam logic [SET_W-1:0] SET_LEFT  = 2'd1;
  localparam logic [SET_W-1:0] SET_RIGHT = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/scws_if.sv =====
// Item channel interfaces: instances in, split statistics out.
interface scws_in_if #(
  parameter int NODE_BITS   = scws_pkg::NODE_BITS_DEF,
  parameter int WEIGHT_BITS = scws_pkg::WEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [NODE_BITS-1:0]          node_code;
  logic [scws_pkg::LABEL_W-1:0]  class_label;
  logic [WEIGHT_BITS-1:0]        weight;
  logic                          last_instance;

  modport source (output valid, node_code, class_label, weight, last_instance, input ready);
  modport sink   (input valid, node_code, class_label, weight, last_instance, output ready);
endinterface

interface scws_out_if;
  logic                               valid;
  logic                               ready;
  logic [scws_pkg::SET_W-1:0]         result_set;
  logic [scws_pkg::CLASS_OUT_W-1:0]   majority_class;
  logic [scws_pkg::WEIGHT_OUT_W-1:0]  correct_weight;
  logic [scws_pkg::WEIGHT_OUT_W-1:0]  total_weight;
  logic [scws_pkg::FRAC_BITS:0]       correct_fraction;
  logic                               empty_set;
  logic                               last_result;

  modport source (output valid, result_set, majority_class, correct_weight, total_weight,
                  correct_fraction, empty_set, last_result, input ready);
  modport sink   (input valid, result_set, majority_class, correct_weight, total_weight,
                  correct_fraction, empty_set, last_result, output ready);
endinterface

// ===== rtl/scws_frac_div.sv =====
// Bit-serial Q1.16 fraction divider: floor(num * 2^16 / den), one bit per cycle.
module scws_frac_div #(
  parameter int SUM_BITS = scws_pkg::SUM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [SUM_BITS-1:0]         num,
  input  logic [SUM_BITS-1:0]         den,
  output scws_pkg::div_stat_t         stat,
  output logic [scws_pkg::FRAC_BITS:0] quot
);

  localparam int FB    = scws_pkg::FRAC_BITS;
  localparam int CNT_W = $clog2(FB + 1);
  localparam logic [FB:0] Q_ONE = {1'b1, {FB{1'b0}}};

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_BITS-1:0] rem_r;
  logic [SUM_BITS-1:0] den_r;
  logic [FB:0]         q_r;
  logic [SUM_BITS:0]   shifted;
  logic [SUM_BITS:0]   diff;
  logic                ge;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (den == '0 || num >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      if (den == '0) begin
        q_r <= '0;
      end else if (num >= den) begin
        q_r <= Q_ONE;
      end else begin
        q_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff[SUM_BITS-1:0] : shifted[SUM_BITS-1:0];
      q_r   <= {q_r[FB-1:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

// ===== rtl/split_class_weight_stats.sv =====
// Per-class weight histograms of a tree split's two children, with majority statistics.
// An instance is accepted only in the idle state, and the next cycle does the read-modify-write
// of its class entry in the registered-read histogram memory (left and right sums share a
// word). The last instance adds a sweep over the n classes in use; the last sweep cycle also
// clears the histograms through per-entry valid bits. Each of the three results then goes
// through the bit-serial Q1.16 divider (which skips its bit loop when the set is empty or its
// majority class holds the whole total) and waits for the sink to take it.
module split_class_weight_stats #(
  parameter int MAX_CLASSES = scws_pkg::MAX_CLASSES_DEF,
  parameter int WEIGHT_BITS = scws_pkg::WEIGHT_BITS_DEF,
  parameter int NODE_BITS   = scws_pkg::NODE_BITS_DEF,
  parameter int SUM_BITS    = scws_pkg::SUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  scws_in_if.sink                             in_ch,
  scws_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [scws_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [scws_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [scws_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CLS_W  = $clog2(MAX_CLASSES);
  localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int CMP_W  = (NODE_BITS > scws_pkg::SPLIT_W + 2) ? NODE_BITS : scws_pkg::SPLIT_W + 2;
  localparam int ADD_W  = ((SUM_BITS > WEIGHT_BITS) ? SUM_BITS : WEIGHT_BITS) + 1;
  localparam int NSETS  = 3;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DIVGO = 3'd3;
  localparam logic [2:0] ST_DIVW  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [scws_pkg::SPLIT_W-1:0] split_node_r;
  logic [scws_pkg::NCLS_W-1:0]  num_classes_r;
  logic [CNT_W-1:0]             n_used;

  // histogram memory: {right, left}
  logic [2*SUM_BITS-1:0] mem [MAX_CLASSES];
  logic [MAX_CLASSES-1:0] vld_r;
  logic [2*SUM_BITS-1:0] mem_q_r;
  logic                  vld_q_r;
  logic [CLS_W-1:0]      mem_raddr;
  logic                  mem_we;
  logic [2*SUM_BITS-1:0] mem_wdata;
  logic [SUM_BITS-1:0]   rd_l, rd_r;

  // instance being updated
  logic [CLS_W-1:0]       upd_idx_r;
  logic [WEIGHT_BITS-1:0] upd_w_r;
  logic                   hit_l_r, hit_r_r, last_r;
  logic [CMP_W-1:0]       left_code, right_code, code_ext;
  logic                   label_ok;
  logic [CLS_W-1:0]       lbl_idx;
  logic [ADD_W-1:0]       upd_sum;
  logic [SUM_BITS-1:0]    upd_new;

  // sweep pipeline
  logic [CNT_W-1:0]     sw_idx_r;
  logic                 sw_issue;
  logic                 rd_v_r;
  logic [CLS_W-1:0]     rd_idx_r;
  logic                 b_v_r;
  logic [CLS_W-1:0]     b_idx_r;
  logic [SUM_BITS-1:0]  b_val_r [NSETS];
  logic [SUM_BITS:0]    both_sum;
  logic [SUM_BITS-1:0]  acc_best_r [NSETS];
  logic [CLS_W-1:0]     acc_cls_r  [NSETS];
  logic [SUM_BITS-1:0]  acc_tot_r  [NSETS];
  logic [SUM_BITS:0]    tot_sum    [NSETS];

  logic [scws_pkg::SET_W-1:0] set_r;
  logic [scws_pkg::FRAC_BITS:0] frac_r;
  logic [scws_pkg::FRAC_BITS:0] div_quot;
  scws_pkg::div_stat_t          div_st;
  logic                         cfg_we;

  // configuration
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_node_r  <= '0;
      num_classes_r <= scws_pkg::NUM_CLASSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        scws_pkg::REG_SPLIT_NODE:  split_node_r  <= cfg_pwdata[scws_pkg::SPLIT_W-1:0];
        scws_pkg::REG_NUM_CLASSES: num_classes_r <= cfg_pwdata[scws_pkg::NCLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      scws_pkg::REG_SPLIT_NODE:
        cfg_prdata = scws_pkg::CFG_DATA_W'(split_node_r);
      scws_pkg::REG_NUM_CLASSES:
        cfg_prdata = scws_pkg::CFG_DATA_W'(num_classes_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign n_used = (32'(num_classes_r) > 32'(MAX_CLASSES)) ? CNT_W'(MAX_CLASSES)
                                                          : CNT_W'(num_classes_r);

  // instance decode
  assign left_code  = CMP_W'({split_node_r, 1'b1});
  assign right_code = left_code + 1'b1;
  assign code_ext   = CMP_W'(in_ch.node_code);
  assign label_ok   = (in_ch.class_label != '0) &&
                      (32'(in_ch.class_label) <= 32'(n_used));
  assign lbl_idx    = CLS_W'(in_ch.class_label - 1'b1);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_l_r <= 1'b0;
      hit_r_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hit_l_r <= label_ok && (code_ext == left_code);
      hit_r_r <= label_ok && (code_ext == right_code);
      last_r  <= in_ch.last_instance;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      upd_idx_r <= lbl_idx;
      upd_w_r   <= in_ch.weight;
    end
  end

  // memory access
  assign sw_issue  = (state_r == ST_SWEEP) && (sw_idx_r < n_used);
  assign mem_raddr = (state_r == ST_IDLE) ? lbl_idx : sw_idx_r[CLS_W-1:0];
  assign rd_l      = vld_q_r ? mem_q_r[SUM_BITS-1:0] : '0;
  assign rd_r      = vld_q_r ? mem_q_r[2*SUM_BITS-1:SUM_BITS] : '0;

  assign upd_sum   = ADD_W'(hit_l_r ? rd_l : rd_r) + ADD_W'(upd_w_r);
  assign upd_new   = (upd_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : upd_sum[SUM_BITS-1:0];
  assign mem_we    = (state_r == ST_UPD) && (hit_l_r || hit_r_r);
  assign mem_wdata = hit_l_r ? {rd_r, upd_new} : {upd_new, rd_l};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[upd_idx_r] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
    vld_q_r <= vld_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (state_r == ST_SWEEP && state_nxt == ST_DIVGO) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[upd_idx_r] <= 1'b1;
    end
  end

  // sweep: read, combine, accumulate
  assign both_sum = {1'b0, rd_l} + {1'b0, rd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      b_v_r  <= 1'b0;
    end else begin
      rd_v_r <= sw_issue;
      b_v_r  <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= sw_idx_r[CLS_W-1:0];
    b_idx_r    <= rd_idx_r;
    b_val_r[0] <= both_sum[SUM_BITS] ? SUM_MAX : both_sum[SUM_BITS-1:0];
    b_val_r[1] <= rd_l;
    b_val_r[2] <= rd_r;
  end

  always_comb begin
    for (int s = 0; s < NSETS; s++) begin
      tot_sum[s] = {1'b0, acc_tot_r[s]} + {1'b0, b_val_r[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      for (int s = 0; s < NSETS; s++) begin
        acc_best_r[s] <= '0;
        acc_cls_r[s]  <= '0;
        acc_tot_r[s]  <= '0;
      end
    end else if (b_v_r) begin
      for (int s = 0; s < NSETS; s++) begin
        acc_tot_r[s] <= tot_sum[s][SUM_BITS] ? SUM_MAX : tot_sum[s][SUM_BITS-1:0];
        if (b_val_r[s] > acc_best_r[s]) begin
          acc_best_r[s] <= b_val_r[s];
          acc_cls_r[s]  <= b_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_idx_r <= '0;
    end else if (state_r == ST_UPD) begin
      sw_idx_r <= '0;
    end else if (sw_issue) begin
      sw_idx_r <= sw_idx_r + 1'b1;
    end
  end

  // fraction
  scws_frac_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_DIVGO),
    .num   (acc_best_r[set_r]),
    .den   (acc_tot_r[set_r]),
    .stat  (div_st),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVW && div_st.done) begin
      frac_r <= div_quot;
    end
  end

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = last_r ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: if (!sw_issue && !rd_v_r && !b_v_r) state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIVW;
      ST_DIVW:  if (div_st.done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = (set_r == scws_pkg::SET_RIGHT) ? ST_IDLE : ST_DIVGO;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      set_r   <= scws_pkg::SET_NODE;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SWEEP) begin
        set_r <= scws_pkg::SET_NODE;
      end else if (state_r == ST_OUT && out_ch.ready) begin
        set_r <= set_r + 1'b1;
      end
    end
  end

  // result
  assign out_ch.valid            = (state_r == ST_OUT);
  assign out_ch.result_set       = set_r;
  assign out_ch.majority_class   = scws_pkg::CLASS_OUT_W'(acc_cls_r[set_r]);
  assign out_ch.correct_weight   = scws_pkg::WEIGHT_OUT_W'(acc_best_r[set_r]);
  assign out_ch.total_weight     = scws_pkg::WEIGHT_OUT_W'(acc_tot_r[set_r]);
  assign out_ch.correct_fraction = frac_r;
  assign out_ch.empty_set        = (acc_tot_r[set_r] == '0);
  assign out_ch.last_result      = (set_r == scws_pkg::SET_RIGHT);

`include "split_class_weight_stats_assert.svh"

  `SCWS_ASSERT_NOW(a_hist_clear, (state_r == ST_DIVGO) && (set_r == scws_pkg::SET_NODE), vld_r == '0, "histograms not cleared before results")
  `SCWS_ASSERT_NEXT(a_last_sweeps, (state_r == ST_UPD) && last_r, state_r == ST_SWEEP, "last item did not start the sweep")
  `SCWS_ASSERT_NOW(a_best_le_tot, state_r == ST_OUT, acc_best_r[set_r] <= acc_tot_r[set_r], "majority weight above total")
  `SCWS_ASSERT_NOW(a_div_alive, state_r == ST_DIVW, div_st.busy || div_st.done, "divider idle while awaited")
  `SCWS_ASSERT_NEXT(a_run_end, out_ch.valid && out_ch.ready && out_ch.last_result, state_r == ST_IDLE, "run did not end after the third result")

endmodule

// ===== verif/tb_split_class_weight_stats.sv =====
// Self-checking bench: random split histograms through the split statistics block vs a predictor.
`timescale 1ns / 100ps

module tb_split_class_weight_stats;

  typedef struct packed {
    logic [scws_pkg::NODE_BITS_DEF-1:0]   node_code;
    logic [scws_pkg::LABEL_W-1:0]         class_label;
    logic [scws_pkg::WEIGHT_BITS_DEF-1:0] weight;
    logic                                 last_instance;
  } instance_t;

  typedef struct packed {
    logic [scws_pkg::SET_W-1:0]        result_set;
    logic [scws_pkg::CLASS_OUT_W-1:0]  majority_class;
    logic [scws_pkg::WEIGHT_OUT_W-1:0] correct_weight;
    logic [scws_pkg::WEIGHT_OUT_W-1:0] total_weight;
    logic [scws_pkg::FRAC_BITS:0]      correct_fraction;
    logic                              empty_set;
    logic                              last_result;
  } split_stats_t;

  typedef logic [scws_pkg::SUM_BITS_DEF-1:0] class_sums_t [scws_pkg::MAX_CLASSES_DEF];

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_CHOKED} rx_mode_t;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [scws_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [scws_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [scws_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  scws_in_if  in_ch();
  scws_out_if out_ch();

  split_class_weight_stats dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state
  logic [scws_pkg::SPLIT_W-1:0] split_cfg = '0;
  logic [scws_pkg::NCLS_W-1:0]  ncls_cfg  = scws_pkg::NUM_CLASSES_RST;
  class_sums_t        left_sums;
  class_sums_t        right_sums;

  instance_t    instance_q [$];
  split_stats_t expected_stats [$];
  instance_t    cur_item;

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int failures     = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left    = 0;
  int mode_left    = 0;
  rx_mode_t rx_mode = RX_FREE;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [scws_pkg::SUM_BITS_DEF-1:0] sat_add40(
      logic [scws_pkg::SUM_BITS_DEF-1:0] a, logic [scws_pkg::SUM_BITS_DEF-1:0] b);
    logic [scws_pkg::SUM_BITS_DEF:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[scws_pkg::SUM_BITS_DEF] ? '1 : s[scws_pkg::SUM_BITS_DEF-1:0];
  endfunction

  function automatic int classes_in_use();
    return (ncls_cfg > scws_pkg::MAX_CLASSES_DEF) ? scws_pkg::MAX_CLASSES_DEF : int'(ncls_cfg);
  endfunction

  function automatic split_stats_t summarize(logic [scws_pkg::SET_W-1:0] which,
                                             class_sums_t sums, int n);
    split_stats_t r;
    logic [scws_pkg::SUM_BITS_DEF-1:0] best;
    logic [scws_pkg::SUM_BITS_DEF-1:0] total;
    logic [63:0] q;
    int cls;
    best = '0;
    total = '0;
    cls = 0;
    for (int j = 0; j < n; j++) begin
      total = sat_add40(total, sums[j]);
      if (j == 0 || sums[j] > best) begin
        best = sums[j];
        cls = j;
      end
    end
    r.result_set = which;
    r.majority_class = cls[scws_pkg::CLASS_OUT_W-1:0];
    r.correct_weight = best;
    r.total_weight = total;
    r.empty_set = (total == 0);
    r.last_result = (which == scws_pkg::SET_RIGHT);
    if (total == 0) begin
      r.correct_fraction = '0;
    end else if (best >= total) begin
      r.correct_fraction = 17'h10000;
    end else begin
      q = ({24'b0, best} << scws_pkg::FRAC_BITS) / {24'b0, total};
      r.correct_fraction = q[scws_pkg::FRAC_BITS:0];
    end
    return r;
  endfunction

  task automatic accumulate_instance(input instance_t it);
    logic [scws_pkg::NODE_BITS_DEF:0] lcode;
    logic [scws_pkg::NODE_BITS_DEF:0] rcode;
    class_sums_t both;
    int n;
    int k;
    lcode = {1'b0, split_cfg, 1'b1};
    rcode = lcode + 1'b1;
    n = classes_in_use();
    if (it.class_label >= 1 && it.class_label <= n) begin
      k = it.class_label - 1;
      if ({1'b0, it.node_code} == lcode)
        left_sums[k] = sat_add40(left_sums[k], {24'b0, it.weight});
      else if ({1'b0, it.node_code} == rcode)
        right_sums[k] = sat_add40(right_sums[k], {24'b0, it.weight});
    end
    if (it.last_instance) begin
      for (int j = 0; j < scws_pkg::MAX_CLASSES_DEF; j++)
        both[j] = sat_add40(left_sums[j], right_sums[j]);
      expected_stats.push_back(summarize(scws_pkg::SET_NODE, both, n));
      expected_stats.push_back(summarize(scws_pkg::SET_LEFT, left_sums, n));
      expected_stats.push_back(summarize(scws_pkg::SET_RIGHT, right_sums, n));
      for (int j = 0; j < scws_pkg::MAX_CLASSES_DEF; j++) begin
        left_sums[j] = '0;
        right_sums[j] = '0;
      end
    end
  endtask

  // sender: bursts and gaps
  always @(posedge clk) begin : sender
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accumulate_instance(cur_item);
        accepted_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (instance_q.size() > 0) begin
          cur_item = instance_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.node_code     <= cur_item.node_code;
          in_ch.class_label   <= cur_item.class_label;
          in_ch.weight        <= cur_item.weight;
          in_ch.last_instance <= cur_item.last_instance;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus an occasional long hold-off
  always @(posedge clk) begin : receiver
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_ack_cnt != hold_req_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_RANDOM: rdy = ($urandom_range(0, 1) != 0);
        default:   rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : monitor
    split_stats_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $error("result_set: expected none, got %0d", out_ch.result_set);
        failures++;
      end else begin
        e = expected_stats.pop_front();
        check_field("result_set", e.result_set, out_ch.result_set);
        check_field("majority_class", e.majority_class, out_ch.majority_class);
        check_field("correct_weight", e.correct_weight, out_ch.correct_weight);
        check_field("total_weight", e.total_weight, out_ch.total_weight);
        check_field("correct_fraction", e.correct_fraction, out_ch.correct_fraction);
        check_field("empty_set", e.empty_set, out_ch.empty_set);
        check_field("last_result", e.last_result, out_ch.last_result);
      end
    end
  end

  task automatic push_instance(input int code, input int label, input int w, input bit last);
    instance_t it;
    it.node_code = code[scws_pkg::NODE_BITS_DEF-1:0];
    it.class_label = label[scws_pkg::LABEL_W-1:0];
    it.weight = w[scws_pkg::WEIGHT_BITS_DEF-1:0];
    it.last_instance = last;
    instance_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [scws_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == scws_pkg::REG_SPLIT_NODE)
      split_cfg = value[scws_pkg::SPLIT_W-1:0];
    else
      ncls_cfg = value[scws_pkg::NCLS_W-1:0];
  endtask

  // upper bits are junk, the block must mask them
  task automatic configure(input int split, input int ncls);
    write_reg(scws_pkg::REG_SPLIT_NODE, ($urandom & 32'hFFFF_8000) | split);
    write_reg(scws_pkg::REG_NUM_CLASSES, ($urandom & 32'hFFFF_FFE0) | ncls);
  endtask

  task automatic wait_drained();
    while (!(accepted_cnt == queued_cnt && expected_stats.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one data set, mostly instances that land in a child histogram
  task automatic queue_random_set();
    int len;
    int lcode;
    int code;
    int label;
    int w;
    int n;
    int sel;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
    n = classes_in_use();
    lcode = 2 * split_cfg + 1;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 3);
      w = (sel == 0) ? 65535 : (sel == 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
      if ($urandom_range(0, 9) < 8) begin
        code = (lcode < 65535 && $urandom_range(0, 1)) ? lcode + 1 : lcode;
        label = (n > 0) ? $urandom_range(1, n) : $urandom_range(1, scws_pkg::MAX_CLASSES_DEF);
      end else begin
        code = $urandom_range(0, 65535);
        label = $urandom_range(0, 31);
      end
      push_instance(code, label, w, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int phase;
    int split;
    int ncls;
    int r;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.node_code = '0;
    in_ch.class_label = '0;
    in_ch.weight = '0;
    in_ch.last_instance = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int j = 0; j < scws_pkg::MAX_CLASSES_DEF; j++) begin
      left_sums[j] = '0;
      right_sums[j] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: children are codes 1 and 2, two classes
    push_instance(7, 1, 100, 1);        // nothing matches: empty sets
    push_instance(1, 1, 65535, 0);
    push_instance(1, 2, 65535, 0);      // tie, lower class wins
    push_instance(2, 2, 3, 0);
    push_instance(2, 3, 50, 0);         // label above class count
    push_instance(0, 1, 5, 0);
    push_instance(1, 0, 9, 0);          // label zero
    push_instance(2, 1, 0, 1);
    wait_drained();

    // top split node: right child code does not fit, never matches
    configure(32767, 16);
    push_instance(65535, 16, 65535, 0);
    push_instance(65535, 1, 1, 0);
    push_instance(0, 17, 200, 0);
    push_instance(65535, 31, 7, 0);
    push_instance(65535, 16, 12345, 1);
    wait_drained();

    // class count beyond the maximum acts as the maximum
    configure(1234, 31);
    push_instance(2469, 16, 1000, 0);
    push_instance(2470, 17, 555, 0);
    push_instance(2470, 5, 40000, 0);
    push_instance(2470, 5, 1, 1);
    wait_drained();

    // zero classes accepts nothing
    configure(1234, 0);
    push_instance(2469, 1, 10, 0);
    push_instance(2470, 2, 20, 1);
    wait_drained();

    configure(0, 1);
    push_instance(1, 1, 7, 0);
    push_instance(2, 2, 5, 0);
    push_instance(2, 1, 3, 1);
    wait_drained();

    phase = 0;
    while (queued_cnt < 180) begin
      r = $urandom_range(0, 9);
      split = (r == 0) ? 0 : (r == 1) ? 32767 : (r < 5) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 32767);
      r = $urandom_range(0, 9);
      ncls = (r < 7) ? $urandom_range(2, 16) : (r == 7) ? 2 : (r == 8) ? 16
             : ($urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31));
      configure(split, ncls);
      if (phase == 1) begin
        @(posedge clk);
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (8) queue_random_set();
      end else begin
        repeat ($urandom_range(2, 5)) queue_random_set();
      end
      wait_drained();
      phase++;
    end

    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
